/* design/cvf_pkg.sv */
// Package for the channel volume fader: types, constants and codes.
`timescale 1ns / 1ps
`default_nettype none
package cvf_pkg;

   // Field widths fixed by the interface
   localparam int unsigned CMD_W       = 2;
   localparam int unsigned CH_W        = 5;
   localparam int unsigned RATE_W      = 12;
   localparam int unsigned VOL_W       = 16;
   localparam int unsigned ACTIVE_W    = 6;
   localparam int unsigned RAMP_W      = 16;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned CSR_DATA_W  = 16;
   // rate is Q4.8, so the product drops eight fraction bits
   localparam int unsigned RATE_FRAC   = 8;
   localparam int unsigned STEP_W      = RAMP_W + RATE_W - RATE_FRAC;

   localparam int unsigned NUM_CHANNELS_DEFAULT = 32;
   localparam int unsigned QUEUE_DEPTH          = 2;

   localparam logic [VOL_W-1:0]  FULL_SCALE      = 16'h8000;
   localparam logic [RAMP_W-1:0] RAMP_STEP_RESET = 16'd1638;

   // Input command codes
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MUTE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNMUTE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_CHANNELS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEP       = 1'd1;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_MUTE   = 2'd1,
      OP_UNMUTE = 2'd2
   } op_type;

   // One classified transaction waiting for the back end
   typedef struct packed {
      op_type            op;
      logic [CH_W-1:0]   ch;
      logic [STEP_W-1:0] step;
   } queue_item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage
`default_nettype wire

/* design/channel_volume_fader_unit.sv */
// Top level of the per-channel linear mute fader.
// Order: a mute/unmute passes through the queue and then sets its mask bit; a tick's first
//   result enters the result register once a second changed channel is found, else at
//   the walk's end, and output stalls can delay it.
// Throughput: a tick holds the back end through pop, walk (one channel of the volume
//   store per cycle unless a held result waits on the output) and drain, plus output
//   stalls; mute/unmute retire one per cycle while no tick holds the back end.
// Reset (synchronous, active high): all unmuted, volumes 0, active_channels 0,
//   ramp_step 1638, queue and result register empty.
`timescale 1ns / 1ps
`default_nettype none
module channel_volume_fader_unit #(
   parameter int unsigned NUM_CHANNELS = cvf_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [cvf_pkg::CMD_W-1:0]         req_command,
   input  wire logic [cvf_pkg::CH_W-1:0]          req_channel,
   input  wire logic [cvf_pkg::RATE_W-1:0]        req_rate,
   // result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [cvf_pkg::CH_W-1:0]               rsp_out_channel,
   output logic [cvf_pkg::VOL_W-1:0]              rsp_volume,
   output logic                                   rsp_last,
   // register write port
   input  wire logic                              csr_we,
   input  wire logic [cvf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [cvf_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cvf_pkg::*;

   logic [ACTIVE_W-1:0] active_ff, active_in;
   logic [RAMP_W-1:0]   ramp_ff,   ramp_in;

   queue_status_type q_status;
   queue_item_type   push_item, pop_item;
   logic             q_push, q_pop;

   // config registers: to be written only while idle (the user's duty, not enforced here), so no shadowing needed
   always_comb begin
      active_in = active_ff;
      ramp_in   = ramp_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE_CHANNELS: active_in = csr_wdata[ACTIVE_W-1:0];
            CSR_RAMP_STEP:       ramp_in   = csr_wdata[RAMP_W-1:0];
            default:             active_in = active_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         ramp_ff   <= RAMP_STEP_RESET;
      end else begin
         active_ff <= active_in;
         ramp_ff   <= ramp_in;
      end
   end

   // front end: classify, drop unused/out-of-range commands, compute tick step
   cvf_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_channel (req_channel),
      .req_rate    (req_rate),
      .ramp_step   (ramp_ff),
      .q_status    (q_status),
      .q_push      (q_push),
      .q_item      (push_item)
   );

   // decoupling queue: front keeps taking transactions while a tick walks, until the queue is full
   cvf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   // back end: one channel per cycle unless a held result waits on the output; holds one hit back to know which is last
   cvf_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .active_channels (active_ff),
      .q_status        (q_status),
      .q_item          (pop_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_volume      (rsp_volume),
      .rsp_last        (rsp_last)
   );

   // volume never leaves [0, full scale]
   a_vol_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_volume <= FULL_SCALE))
      else $error("volume above full scale");

   // only existing channels are reported
   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_out_channel) < NUM_CHANNELS))
      else $error("result for nonexistent channel");

   // queue status is coherent
   a_q_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.empty && q_status.full))
      else $error("queue both empty and full");

   // a pop always finds an entry
   a_q_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule
`default_nettype wire

/* design/cvf_front.sv */
// Front end: classifies request transactions and computes the tick step.
`timescale 1ns / 1ps
`default_nettype none
module cvf_front #(
   parameter int unsigned NUM_CHANNELS = cvf_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [cvf_pkg::CMD_W-1:0]     req_command,
   input  wire logic [cvf_pkg::CH_W-1:0]      req_channel,
   input  wire logic [cvf_pkg::RATE_W-1:0]    req_rate,
   input  wire logic [cvf_pkg::RAMP_W-1:0]    ramp_step,
   input  wire cvf_pkg::queue_status_type     q_status,
   output logic                               q_push,
   output cvf_pkg::queue_item_type            q_item
);
   import cvf_pkg::*;

   logic [RAMP_W+RATE_W-1:0] product;
   logic                     keep;

   assign product   = RAMP_W'(ramp_step) * (RAMP_W + RATE_W)'(req_rate);
   assign req_ready = !q_status.full;

   always_comb begin
      keep       = 1'b0;
      q_item.op  = OP_TICK;
      q_item.ch  = req_channel;
      q_item.step = product[RAMP_W+RATE_W-1:RATE_FRAC];
      unique case (req_command)
         CMD_TICK: begin
            keep = 1'b1;
         end
         CMD_MUTE: begin
            keep      = (32'(req_channel) < NUM_CHANNELS);
            q_item.op = OP_MUTE;
         end
         CMD_UNMUTE: begin
            keep      = (32'(req_channel) < NUM_CHANNELS);
            q_item.op = OP_UNMUTE;
         end
         default: begin
            keep = 1'b0;   // unused code: dropped
         end
      endcase
   end

   // dropped commands are still taken, they just never enter the queue
   assign q_push = req_valid && req_ready && keep;

endmodule
`default_nettype wire

/* design/cvf_queue.sv */
// Short queue between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module cvf_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire cvf_pkg::queue_item_type   push_item,
   input  wire logic                      pop,
   output cvf_pkg::queue_item_type        pop_item,
   output cvf_pkg::queue_status_type      status
);
   import cvf_pkg::*;

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_item_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

/* design/cvf_back.sv */
// Back end: mute mask, volume store, channel walk and result register.
`timescale 1ns / 1ps
`default_nettype none
module cvf_back #(
   parameter int unsigned NUM_CHANNELS = cvf_pkg::NUM_CHANNELS_DEFAULT
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [cvf_pkg::ACTIVE_W-1:0]   active_channels,
   input  wire cvf_pkg::queue_status_type      q_status,
   input  wire cvf_pkg::queue_item_type        q_item,
   output logic                                q_pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [cvf_pkg::CH_W-1:0]            rsp_out_channel,
   output logic [cvf_pkg::VOL_W-1:0]           rsp_volume,
   output logic                                rsp_last
);
   import cvf_pkg::*;

   localparam int unsigned IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [NUM_CHANNELS-1:0] mask_ff, mask_in;
   logic [VOL_W-1:0]   vol_ff [NUM_CHANNELS];
   logic [VOL_W-1:0]   vol_in [NUM_CHANNELS];
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   last_idx_ff, last_idx_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]   pend_ch_ff, pend_ch_in;
   logic [VOL_W-1:0]   pend_vol_ff, pend_vol_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CH_W-1:0]    rsp_ch_ff, rsp_ch_in;
   logic [VOL_W-1:0]   rsp_vol_ff, rsp_vol_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [ACTIVE_W-1:0] walk_count;
   logic [VOL_W-1:0]    cur_v, new_v;
   logic [STEP_W:0]     up_sum;
   logic                muted, hit, out_busy, walk_stall, load_mid, load_end;

   // count clamp to the channels that exist
   assign walk_count = (32'(active_channels) > NUM_CHANNELS) ?
                       ACTIVE_W'(NUM_CHANNELS) : active_channels;

   // per-channel ramp for the channel under the walk pointer
   assign cur_v  = vol_ff[idx_ff];
   assign muted  = mask_ff[idx_ff];
   assign up_sum = (STEP_W + 1)'(cur_v) + (STEP_W + 1)'(step_ff);
   always_comb begin
      if (muted) begin
         hit   = (cur_v != '0);
         new_v = (step_ff >= STEP_W'(cur_v)) ? '0 : cur_v - step_ff[VOL_W-1:0];
      end else begin
         hit   = (cur_v < FULL_SCALE);
         new_v = (up_sum > (STEP_W + 1)'(FULL_SCALE)) ? FULL_SCALE : up_sum[VOL_W-1:0];
      end
   end

   assign out_busy   = rsp_valid_ff && !rsp_ready;
   // a second hit needs the held one moved out first
   assign walk_stall = hit && pend_valid_ff && out_busy;
   assign load_mid   = (state_ff == ST_WALK) && hit && pend_valid_ff && !out_busy;
   assign load_end   = (state_ff == ST_DONE) && pend_valid_ff && !out_busy;
   assign q_pop      = (state_ff == ST_IDLE) && !q_status.empty;

   always_comb begin
      state_in      = state_ff;
      mask_in       = mask_ff;
      vol_in        = vol_ff;
      idx_in        = idx_ff;
      last_idx_in   = last_idx_ff;
      step_in       = step_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      pend_vol_in   = pend_vol_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               unique case (q_item.op)
                  OP_MUTE:   mask_in[q_item.ch[IDX_W-1:0]] = 1'b1;
                  OP_UNMUTE: mask_in[q_item.ch[IDX_W-1:0]] = 1'b0;
                  OP_TICK: begin
                     step_in     = q_item.step;
                     idx_in      = '0;
                     last_idx_in = IDX_W'(walk_count - 1'b1);
                     if (walk_count != '0) begin
                        state_in = ST_WALK;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (!walk_stall) begin
               if (hit) begin
                  vol_in[idx_ff] = new_v;
                  pend_valid_in  = 1'b1;
                  pend_ch_in     = idx_ff;
                  pend_vol_in    = new_v;
               end
               idx_in = idx_ff + 1'b1;
               if (idx_ff == last_idx_ff) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (!out_busy) begin
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_ch_in   = rsp_ch_ff;
      rsp_vol_in  = rsp_vol_ff;
      rsp_last_in = rsp_last_ff;
      if (load_mid || load_end) begin
         rsp_valid_in = 1'b1;
         rsp_ch_in    = CH_W'(pend_ch_ff);
         rsp_vol_in   = pend_vol_ff;
         rsp_last_in  = load_end;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mask_ff       <= '0;
         vol_ff        <= '{default: '0};
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mask_ff       <= mask_in;
         vol_ff        <= vol_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      last_idx_ff <= last_idx_in;
      step_ff     <= step_in;
      pend_ch_ff  <= pend_ch_in;
      pend_vol_ff <= pend_vol_in;
      rsp_ch_ff   <= rsp_ch_in;
      rsp_vol_ff  <= rsp_vol_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_volume      = rsp_vol_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

/* tb/tb_channel_volume_fader_unit.sv */
// Self-checking testbench for the channel volume fader: directed and random transactions.
`timescale 1ns / 1ps
module tb_channel_volume_fader_unit;
   import cvf_pkg::*;

   // command 3 has no meaning in the block; it must be swallowed silently
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
   localparam int unsigned NUM_CH = NUM_CHANNELS_DEFAULT;
   // a tick holds the back end for its walk of up to 32 channels plus pop and drain
   localparam int unsigned SETTLE_CYCLES = 48;
   localparam int unsigned IDLE_PCT = 34;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned ITEMS_PER_PHASE = 54;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [CH_W-1:0]   channel;
      logic [RATE_W-1:0] rate;
   } fader_req_type;

   typedef struct packed {
      logic [CH_W-1:0]  channel;
      logic [VOL_W-1:0] volume;
      logic             last;
   } level_update_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CMD_W-1:0]      req_command = CMD_TICK;
   logic [CH_W-1:0]       req_channel = '0;
   logic [RATE_W-1:0]     req_rate = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [CH_W-1:0]       rsp_out_channel;
   logic [VOL_W-1:0]      rsp_volume;
   logic                  rsp_last;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ACTIVE_CHANNELS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   channel_volume_fader_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_channel     (req_channel),
      .req_rate        (req_rate),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_channel (rsp_out_channel),
      .rsp_volume      (rsp_volume),
      .rsp_last        (rsp_last),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the fader state, updated when a transaction is accepted
   logic [ACTIVE_W-1:0] shadow_active = '0;
   logic [RAMP_W-1:0]   shadow_ramp = RAMP_STEP_RESET;
   logic [NUM_CH-1:0]   shadow_muted = '0;
   logic [VOL_W-1:0]    shadow_level [NUM_CH];

   // Work waiting to go out, and volume updates the block still owes us
   fader_req_type    pending_reqs[$];
   level_update_type owed_updates[$];

   logic        steady = 1'b0;     // suppresses idling on both sides
   logic        req_taken = 1'b0;  // request handshake at the last rising edge
   int unsigned reqs_queued = 0;
   int unsigned reqs_accepted = 0;
   int unsigned ticks_accepted = 0;
   int unsigned updates_checked = 0;
   int unsigned settings_used = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   initial begin
      for (int i = 0; i < NUM_CH; i++) shadow_level[i] = '0;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatch_count++;
      $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
               cycle_count, what, got, want);
   endtask

   // Mute/unmute edit the mask; a tick walks the channels and ramps each one
   // toward its target, clamping at 0 and full scale. Any channel not already
   // at its target yields an update, even when the step works out to zero.
   task automatic predict_fader(input logic [CMD_W-1:0] command,
                                input logic [CH_W-1:0] channel,
                                input logic [RATE_W-1:0] rate);
      int unsigned walk;
      int unsigned step;
      int unsigned level;
      int unsigned emitted;
      logic        hit;
      level_update_type upd;
      emitted = 0;
      case (command)
         CMD_MUTE: begin
            shadow_muted[channel] = 1'b1;
         end
         CMD_UNMUTE: begin
            shadow_muted[channel] = 1'b0;
         end
         CMD_TICK: begin
            ticks_accepted++;
            // counts past the channel total only walk the channels that exist
            walk = (shadow_active > NUM_CH) ? NUM_CH : shadow_active;
            step = (32'(shadow_ramp) * 32'(rate)) >> RATE_FRAC;
            for (int i = 0; i < walk; i++) begin
               level = shadow_level[i];
               hit = 1'b0;
               if (shadow_muted[i]) begin
                  if (level > 0) begin
                     level = (step >= level) ? 0 : level - step;
                     hit = 1'b1;
                  end
               end else if (level < FULL_SCALE) begin
                  level = level + step;
                  if (level > FULL_SCALE) level = FULL_SCALE;
                  hit = 1'b1;
               end
               if (hit) begin
                  shadow_level[i] = VOL_W'(level);
                  upd.channel = CH_W'(i);
                  upd.volume = VOL_W'(level);
                  upd.last = 1'b0;
                  owed_updates.push_back(upd);
                  emitted++;
               end
            end
            // flag the final update of this tick
            if (emitted > 0) owed_updates[$].last = 1'b1;
         end
         default: begin
            // spare command: no effect
         end
      endcase
   endtask

   // Monitor: take accepted transactions into the shadow model and check
   // every accepted result against the oldest owed update.
   always @(posedge clock) begin
      level_update_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (owed_updates.size() == 0) begin
               report_mismatch("unexpected result, channel", rsp_out_channel, 0);
            end else begin
               want = owed_updates.pop_front();
               updates_checked++;
               if (rsp_out_channel !== want.channel)
                  report_mismatch("out_channel", rsp_out_channel, want.channel);
               if (rsp_volume !== want.volume)
                  report_mismatch("volume", rsp_volume, want.volume);
               if (rsp_last !== want.last)
                  report_mismatch("last", rsp_last, want.last);
            end
         end
         if (req_valid && req_ready) begin
            predict_fader(req_command, req_channel, req_rate);
            reqs_accepted++;
         end
      end
   end

   // Driver: presents queued transactions at the falling edge and holds each
   // one steady until the block takes it.
   always @(negedge clock) begin
      fader_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            nxt = pending_reqs.pop_front();
            req_valid   <= 1'b1;
            req_command <= nxt.command;
            req_channel <= nxt.channel;
            req_rate    <= nxt.rate;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TIMEOUT after %0d cycles, %0d updates still owed",
                  cycle_count, owed_updates.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic queue_req(input logic [CMD_W-1:0] command, input logic [CH_W-1:0] channel,
                            input logic [RATE_W-1:0] rate);
      fader_req_type r;
      r.command = command;
      r.channel = channel;
      r.rate = rate;
      pending_reqs.push_back(r);
      reqs_queued++;
   endtask

   // Register writes happen only with the block idle; the shadow copy follows.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_ACTIVE_CHANNELS) shadow_active = data[ACTIVE_W-1:0];
      else shadow_ramp = data;
   endtask

   task automatic set_fader(input int unsigned active, input int unsigned ramp);
      write_csr(CSR_ACTIVE_CHANNELS, CSR_DATA_W'(active));
      write_csr(CSR_RAMP_STEP, CSR_DATA_W'(ramp));
      settings_used++;
   endtask

   // Wait until every transaction is in and every update is out, then let a
   // tick with no results finish its walk before anything else changes.
   task automatic wait_quiet();
      while (reqs_accepted != reqs_queued || owed_updates.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int unsigned pick;
      int unsigned made;
      logic [CMD_W-1:0]  cmd;
      logic [RATE_W-1:0] rate;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // --- directed ---
      // zero channels in use: a tick walks nothing
      queue_req(CMD_TICK, 5'd0, 12'd256);
      wait_quiet();

      set_fader(32, RAMP_STEP_RESET);
      queue_req(CMD_TICK, 5'd0, 12'd256);         // unit rate, all ramp up
      queue_req(CMD_TICK, 5'd0, 12'hFFF);         // largest rate
      queue_req(CMD_TICK, 5'd0, 12'd0);           // zero step, values unchanged
      queue_req(CMD_MUTE, 5'd0, 12'hFFF);         // rate ignored on mute
      queue_req(CMD_MUTE, 5'd31, 12'd0);
      queue_req(CMD_MUTE, 5'd5, 12'h555);
      queue_req(CMD_SPARE, 5'd17, 12'hABC);       // spare command, ignored
      queue_req(CMD_TICK, 5'd31, 12'hFFF);        // channel ignored on tick; top clamp
      queue_req(CMD_TICK, 5'd10, 12'hFFF);        // muted ones clamp at zero
      queue_req(CMD_TICK, 5'd0, 12'd256);         // everything at target: no results
      queue_req(CMD_UNMUTE, 5'd0, 12'd0);
      queue_req(CMD_UNMUTE, 5'd5, 12'hAAA);
      queue_req(CMD_TICK, 5'd0, 12'd1);           // tiny rate
      wait_quiet();

      // count above the channel total, largest ramp step
      set_fader(63, 65535);
      queue_req(CMD_TICK, 5'd0, 12'hFFF);
      queue_req(CMD_MUTE, 5'd0, 12'd0);
      queue_req(CMD_TICK, 5'd0, 12'd3);
      wait_quiet();

      // zero ramp step: a muted channel above zero reports its volume unchanged
      set_fader(1, 0);
      queue_req(CMD_TICK, 5'd0, 12'hFFF);
      queue_req(CMD_TICK, 5'd0, 12'd0);
      wait_quiet();

      // --- random phases, each under its own register setting ---
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: set_fader(32, RAMP_STEP_RESET);
            1: set_fader($urandom_range(31, 1), $urandom_range(4000));
            2: set_fader(63, 65535);
            3: set_fader(33, $urandom_range(65535));
            4: set_fader(1, 200);
            default: set_fader($urandom_range(63), $urandom_range(3000, 1));
         endcase
         // one phase runs with no idling on either side
         steady = (phase == 1);
         made = 0;
         while (made < ITEMS_PER_PHASE) begin
            pick = $urandom_range(99);
            if (pick < 45) cmd = CMD_TICK;
            else if (pick < 70) cmd = CMD_MUTE;
            else if (pick < 95) cmd = CMD_UNMUTE;
            else cmd = CMD_SPARE;
            // mostly gentle rates so volumes pass through the middle range
            rate = ($urandom_range(3) == 0) ? RATE_W'($urandom_range(4095))
                                            : RATE_W'($urandom_range(48));
            queue_req(cmd, CH_W'($urandom_range(31)), rate);
            if (cmd != CMD_SPARE) made++;
         end
         wait_quiet();
         steady = 1'b0;
      end

      $display("Covered %0d transactions (%0d ticks) under %0d register settings;",
               reqs_accepted, ticks_accepted, settings_used);
      $display("checked %0d volume updates, %0d mismatches.", updates_checked,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
